FILE: hw/rtl/met_pkg.sv
`default_nettype none

package met_pkg;

    // Plane values: signed Q4.28
    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Iteration limit and result byte
    localparam int MAX_ITER = 255;
    localparam int ITER_W   = $clog2(MAX_ITER + 1);
    localparam int OUT_W    = 8;
    localparam int OUT_MAX  = (1 << OUT_W) - 1;

    // Request fields
    localparam int TILE_W = 16;
    localparam int PIX_W  = 12;
    localparam int STEP_W = 31;

    localparam int TCOL_LSB = 0;
    localparam int TROW_LSB = TCOL_LSB + TILE_W;
    localparam int PCOL_LSB = TROW_LSB + TILE_W;
    localparam int PROW_LSB = PCOL_LSB + PIX_W;
    localparam int STEP_LSB = PROW_LSB + PIX_W;
    localparam int REQ_BITS = STEP_LSB + STEP_W;
    localparam int S_DATA_W = ((REQ_BITS + 7) / 8) * 8;

    // Tile size register
    localparam int TILE_SIDE_MAX = 4096;
    localparam int TS_W          = 13;
    localparam int TSV_W         = $clog2(TILE_SIDE_MAX + 1);

    // Pixel index, offset and coordinate sum widths
    localparam longint IDX_MAX = ((longint'(1) << TILE_W) - 1) * longint'(TILE_SIDE_MAX)
                                 + ((longint'(1) << PIX_W) - 1);
    localparam int IDX_W = $clog2(IDX_MAX + 1);
    localparam int OFF_W = IDX_W + STEP_W;
    localparam int SUM_W = OFF_W + 2;

    // Products of z, 2*FRAC_BITS fraction bits
    localparam int ZP_W = 2 * Q_W;
    localparam logic [ZP_W-1:0] ESC_LIMIT = ZP_W'(4) << (2 * FRAC_BITS);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_MIN     = 2'd0,
        REG_Y_MAX     = 2'd1,
        REG_TILE_SIDE = 2'd2
    } t_cfg_reg;

    localparam logic signed [Q_W-1:0] X_MIN_RST     = -32'sd536870912;
    localparam logic signed [Q_W-1:0] Y_MAX_RST     = 32'sd536870912;
    localparam logic [TSV_W-1:0]      TILE_SIDE_RST = TSV_W'(256);

    // Point of the plane handed from front to back
    typedef struct packed {
        logic signed [Q_W-1:0] c_imag;
        logic signed [Q_W-1:0] c_real;
    } t_point;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    function automatic logic signed [Q_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SUM_W'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < SUM_W'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_z(input logic signed [ZP_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > ZP_W'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < ZP_W'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic [ITER_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (32'(v) > 32'(OUT_MAX)) begin
            r = OUT_W'(OUT_MAX);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/met_front.sv
`default_nettype none

module met_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    input  wire [met_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [met_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           i_s_valid,
    output logic                          o_s_ready,
    input  wire [met_pkg::S_DATA_W-1:0]   i_s_data,
    output logic                          o_q_push,
    input  wire                           i_q_ready,
    output met_pkg::t_point               o_q_point
);
    import met_pkg::*;

    logic signed [Q_W-1:0] r_x_min;
    logic signed [Q_W-1:0] r_y_max;
    logic [TSV_W-1:0]      r_tile_side;
    logic [TS_W-1:0]       w_ts_wr;

    logic                  r_v1;
    logic                  r_v2;
    logic [IDX_W-1:0]      r_idx_r;
    logic [IDX_W-1:0]      r_idx_i;
    logic [STEP_W-1:0]     r_step;
    logic [OFF_W-1:0]      r_off_r;
    logic [OFF_W-1:0]      r_off_i;
    logic                  w_en;

    logic [TILE_W-1:0]     w_tcol;
    logic [TILE_W-1:0]     w_trow;
    logic [PIX_W-1:0]      w_pcol;
    logic [PIX_W-1:0]      w_prow;
    logic [STEP_W-1:0]     w_step;
    logic signed [SUM_W-1:0] w_sum_r;
    logic signed [SUM_W-1:0] w_sum_i;

    assign w_ts_wr = i_cfg_data[TS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min     <= X_MIN_RST;
            r_y_max     <= Y_MAX_RST;
            r_tile_side <= TILE_SIDE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_X_MIN:     r_x_min <= i_cfg_data[Q_W-1:0];
                REG_Y_MAX:     r_y_max <= i_cfg_data[Q_W-1:0];
                REG_TILE_SIDE: begin
                    if (32'(w_ts_wr) > 32'(TILE_SIDE_MAX)) begin
                        r_tile_side <= TSV_W'(TILE_SIDE_MAX);
                    end else begin
                        r_tile_side <= TSV_W'(w_ts_wr);
                    end
                end
                default: ;
            endcase
        end
    end

    assign w_tcol = i_s_data[TCOL_LSB +: TILE_W];
    assign w_trow = i_s_data[TROW_LSB +: TILE_W];
    assign w_pcol = i_s_data[PCOL_LSB +: PIX_W];
    assign w_prow = i_s_data[PROW_LSB +: PIX_W];
    assign w_step = i_s_data[STEP_LSB +: STEP_W];

    // advance the whole pipe unless the last stage cannot push
    assign w_en      = !r_v2 || i_q_ready;
    assign o_s_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx_r <= IDX_W'(w_tcol) * IDX_W'(r_tile_side) + IDX_W'(w_pcol);
            r_idx_i <= IDX_W'(w_trow) * IDX_W'(r_tile_side) + IDX_W'(w_prow);
            r_step  <= w_step;
            r_off_r <= OFF_W'(r_idx_r) * OFF_W'(r_step);
            r_off_i <= OFF_W'(r_idx_i) * OFF_W'(r_step);
        end
    end

    assign w_sum_r = SUM_W'(r_x_min) + $signed({2'b00, r_off_r});
    assign w_sum_i = SUM_W'(r_y_max) - $signed({2'b00, r_off_i});

    assign o_q_push         = r_v2 && i_q_ready;
    assign o_q_point.c_real = sat_coord(w_sum_r);
    assign o_q_point.c_imag = sat_coord(w_sum_i);

endmodule

`default_nettype wire

FILE: hw/rtl/met_queue.sv
`default_nettype none

module met_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_ready,
    input  wire met_pkg::t_point i_point,
    output logic                 o_valid,
    input  wire                  i_pop,
    output met_pkg::t_point      o_point
);
    import met_pkg::*;

    t_point              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_ready = r_cnt != QCNT_W'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_point = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_point;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/met_core.sv
`default_nettype none

module met_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_q_valid,
    output logic                     o_q_pop,
    input  wire met_pkg::t_point     i_q_point,
    output logic                     o_m_valid,
    input  wire                      i_m_ready,
    output logic [met_pkg::OUT_W-1:0] o_m_data
);
    import met_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_UPD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [ITER_W-1:0]      r_cnt, n_cnt;
    logic [ITER_W-1:0]      r_res, n_res;
    logic signed [Q_W-1:0]  r_zr, n_zr;
    logic signed [Q_W-1:0]  r_zi, n_zi;
    logic signed [Q_W-1:0]  r_cr, n_cr;
    logic signed [Q_W-1:0]  r_ci, n_ci;
    logic signed [ZP_W-1:0] r_rr, n_rr;
    logic signed [ZP_W-1:0] r_ii, n_ii;
    logic signed [ZP_W-1:0] r_ri, n_ri;
    logic                   r_ov, n_ov;
    logic [OUT_W-1:0]       r_od, n_od;

    logic [ZP_W-1:0]        w_mag;
    logic signed [ZP_W-1:0] w_nr;
    logic signed [ZP_W-1:0] w_ni;
    logic                   w_esc;

    // |z|^2 of the z whose squares sit in r_rr and r_ii
    assign w_mag = $unsigned(r_rr) + $unsigned(r_ii);
    assign w_esc = (r_cnt != '0) && (w_mag > ESC_LIMIT);
    assign w_nr  = ((r_rr - r_ii) >>> FRAC_BITS) + ZP_W'(r_cr);
    assign w_ni  = (r_ri >>> (FRAC_BITS - 1)) + ZP_W'(r_ci);

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_m_valid = r_ov;
    assign o_m_data  = r_od;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_zr    = r_zr;
        n_zi    = r_zi;
        n_cr    = r_cr;
        n_ci    = r_ci;
        n_rr    = r_rr;
        n_ii    = r_ii;
        n_ri    = r_ri;
        n_ov    = r_ov;
        n_od    = r_od;

        if (r_ov && i_m_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cr    = i_q_point.c_real;
                    n_ci    = i_q_point.c_imag;
                    n_zr    = '0;
                    n_zi    = '0;
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_rr    = r_zr * r_zr;
                n_ii    = r_zi * r_zi;
                n_ri    = r_zr * r_zi;
                n_state = S_UPD;
            end
            S_UPD: begin
                // r_cnt iterations done; the escape test belongs to the last one
                priority if (w_esc) begin
                    n_res   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end else if (r_cnt == ITER_W'(MAX_ITER)) begin
                    n_res   = ITER_W'(MAX_ITER);
                    n_state = S_DONE;
                end else begin
                    n_zr    = sat_z(w_nr);
                    n_zi    = sat_z(w_ni);
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!r_ov || i_m_ready) begin
                    n_ov    = 1'b1;
                    n_od    = sat_out(r_res);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_zr  <= n_zr;
        r_zi  <= n_zi;
        r_cr  <= n_cr;
        r_ci  <= n_ci;
        r_rr  <= n_rr;
        r_ii  <= n_ii;
        r_ri  <= n_ri;
        r_od  <= n_od;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_time_pixel.sv
// Channel   Dir  Handshake                      Word
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data (x_min, y_max, tile side)
// s_axis    in   s_axis_tvalid / s_axis_tready  pixel request
// m_axis    out  m_axis_tvalid / m_axis_tready  iteration count
//
// A request is registered as an index, then as an offset, before it reaches the 2-entry
// queue (add and saturate feed the push); the engine pops it from the queue when idle.
// Each iteration of the engine runs S_MUL (squares and cross product), then S_UPD
// (update and escape test). The front keeps taking requests while the engine runs, until
// the queue is full and a point waits at the push. A finished count waits in the output
// register while the engine starts the next word. Reset is synchronous, active low, and
// clears control state and the registers to x_min = -2.0, y_max = 2.0, tile side = 256.
// o_cfg_ready stays high.
`default_nettype none

module mandelbrot_escape_time_pixel (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [met_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [met_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] tile_col, [31:16] tile_row, [43:32] pixel_col, [55:44] pixel_row,
    // [86:56] pixel_step, [87] zero
    input  wire [met_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // [7:0] iterations
    output logic [met_pkg::OUT_W-1:0]     m_axis_tdata
);
    import met_pkg::*;

    logic   w_push;
    logic   w_q_ready;
    t_point w_push_point;
    logic   w_q_valid;
    logic   w_pop;
    t_point w_pop_point;

    assign o_cfg_ready = 1'b1;

    met_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .o_q_push    (w_push),
        .i_q_ready   (w_q_ready),
        .o_q_point   (w_push_point)
    );

    met_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_point (w_push_point),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_point (w_pop_point)
    );

    met_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_pop),
        .i_q_point (w_pop_point),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/met_checker.sv
`default_nettype none

module met_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_cfg_valid,
    input wire                           o_cfg_ready,
    input wire [met_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire [met_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire [met_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [met_pkg::OUT_W-1:0]      m_axis_tdata
);
    import met_pkg::*;

    logic       w_in_acc;
    logic       w_out_acc;
    logic [3:0] r_pend;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            if (w_in_acc && !w_out_acc) begin
                r_pend <= r_pend + 1'b1;
            end else if (w_out_acc && !w_in_acc) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_pend != '0)
        else $error("result delivered without a pending request");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && r_pend == '0 |=> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("result appeared too early");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (.*);

`default_nettype wire
